// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh : concurrent assertion helpers
// Clocked property checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge, held off during reset.
`define ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an expression never holds at a rising edge outside reset.
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   `ASSERT_PROP(name, clk, rst, !(expr), msg)

`else

`define ASSERT_PROP(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)

`endif

`endif

// ===== hdl/shp_pkg.sv =====
// ----------------------------------------------------------------------------
// shp_pkg : shared types and constants of the sharpen block
// Field types, tap codes, register indexes and control groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package shp_pkg;

   localparam int PIX_W        = 8;
   localparam int COORD_W      = 6;
   localparam int SIZE_W       = 7;
   localparam int ACC_W        = 12;
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 7'd2;
   localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      TAP_CENTER = 3'd0,
      TAP_UP     = 3'd1,
      TAP_DOWN   = 3'd2,
      TAP_LEFT   = 3'd3,
      TAP_RIGHT  = 3'd4
   } tap_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [COORD_W-1:0]  pixel_row;
      logic [COORD_W-1:0]  pixel_col;
      logic [PIX_W-1:0]    pixel_value;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]    sharpened_value;
      logic [COORD_W-1:0]  result_row;
      logic [COORD_W-1:0]  result_col;
   } rsp_type;

   // Position and tap handed to the address generator.
   typedef struct packed {
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      tap_type             tap;
   } addr_req_type;

   // Control of the shared accumulator.
   typedef struct packed {
      logic                clear;
      logic                enable;
      tap_type             tap;
   } mac_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/shp_ram.sv =====
// ----------------------------------------------------------------------------
// shp_ram : generic single-port RAM
// One read or write port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shp_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [$clog2(DEPTH)-1:0]   addr,
   input  wire logic [DATA_W-1:0]          wdata,
   output logic      [DATA_W-1:0]          rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/shp_addr_gen.sv =====
// ----------------------------------------------------------------------------
// shp_addr_gen : neighbor address generator
// Mirrors the tap position at the image border and forms the store address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shp_addr_gen #(
   parameter int MAX_ROWS = shp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = shp_pkg::DEF_MAX_COLS
) (
   input  wire shp_pkg::addr_req_type                  areq,
   input  wire logic [shp_pkg::SIZE_W-1:0]             height,
   input  wire logic [shp_pkg::SIZE_W-1:0]             width,
   output logic      [$clog2(MAX_ROWS*MAX_COLS)-1:0]   addr
);

   localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);

   logic [shp_pkg::COORD_W-1:0] row_sel;
   logic [shp_pkg::COORD_W-1:0] col_sel;
   logic [shp_pkg::SIZE_W-1:0]  row_inc;
   logic [shp_pkg::SIZE_W-1:0]  col_inc;

   assign row_inc = {1'b0, areq.row} + 7'd1;
   assign col_inc = {1'b0, areq.col} + 7'd1;

   // Reflect without repeating the edge pixel: -1 maps to 1, N maps to N-2.
   always_comb begin
      row_sel = areq.row;
      col_sel = areq.col;
      case (areq.tap)
         shp_pkg::TAP_CENTER: begin
         end
         shp_pkg::TAP_UP: begin
            row_sel = (areq.row == '0) ? 6'd1 : areq.row - 6'd1;
         end
         shp_pkg::TAP_DOWN: begin
            row_sel = (row_inc >= height) ? 6'(height - 7'd2) : row_inc[5:0];
         end
         shp_pkg::TAP_LEFT: begin
            col_sel = (areq.col == '0) ? 6'd1 : areq.col - 6'd1;
         end
         shp_pkg::TAP_RIGHT: begin
            col_sel = (col_inc >= width) ? 6'(width - 7'd2) : col_inc[5:0];
         end
         default: begin
         end
      endcase
   end

   assign addr = ADDR_W'(row_sel) * ADDR_W'(MAX_COLS) + ADDR_W'(col_sel);

endmodule

`default_nettype wire

// ===== hdl/shp_mac.sv =====
// ----------------------------------------------------------------------------
// shp_mac : shared kernel accumulator
// Adds five times the center and subtracts each edge neighbor, then clamps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shp_mac (
   input  wire logic                          clock,
   input  wire shp_pkg::mac_ctl_type          ctl,
   input  wire logic [shp_pkg::PIX_W-1:0]     data,
   output logic      [shp_pkg::PIX_W-1:0]     value
);

   localparam int AW = shp_pkg::ACC_W;

   // Two's complement, wide enough for -1020 .. 1275.
   logic [AW-1:0] acc_ff;
   logic [AW-1:0] acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.enable) begin
         if (ctl.tap == shp_pkg::TAP_CENTER) begin
            acc_in = acc_ff + AW'({data, 2'b00}) + AW'(data);
         end else begin
            acc_in = acc_ff - AW'(data);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_comb begin
      if (acc_ff[AW-1]) begin
         value = '0;
      end else if (acc_ff[AW-2:shp_pkg::PIX_W] != '0) begin
         value = shp_pkg::PIX_MAX;
      end else begin
         value = acc_ff[shp_pkg::PIX_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sharpen_3x3_reflect_border_top.sv =====
// ----------------------------------------------------------------------------
// sharpen_3x3_reflect_border_top : 3x3 Laplacian sharpen over a stored image
// Pixel store with mirrored-border sharpen reads through one shared unit.
// ----------------------------------------------------------------------------
// Usage:
//   The host loads pixels and reads sharpened pixels through start/busy.
//   A request transfers at a rising edge with start high and busy low.
//   A write (opcode 0) stores its pixel in that same edge and leaves busy
//   low, so writes may go one per cycle. A read (opcode 1) raises busy
//   through five store reads, one per cycle from the single-port pixel RAM,
//   a state (S_LAST) for the last read to land in the accumulator and a
//   state (S_OUT) with rsp_valid high. No new request transfers until the
//   read is through; the single RAM port sets that.
//   Requests whose row or column lie outside the configured size are
//   dropped without a result. The result shows for exactly one cycle,
//   the receiver cannot stall it.
//   Size registers are written on csr_we; the host must do so only while
//   idle (the block does not enforce it). Used sizes clamp to 2 and to
//   MAX_COLS / MAX_ROWS. Reset: idle sequencer, sizes 64, store undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sharpen_3x3_reflect_border_top #(
   parameter int MAX_ROWS = shp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = shp_pkg::DEF_MAX_COLS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire shp_pkg::req_type              req_item,
   output logic                               rsp_valid,
   output shp_pkg::rsp_type                   rsp_item,
   input  wire logic                          csr_we,
   input  wire shp_pkg::csr_index_type        csr_index,
   input  wire logic [shp_pkg::SIZE_W-1:0]    csr_wdata
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FETCH = 4'b0010,
      S_LAST  = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   shp_pkg::tap_type                tap_ff, tap_in;
   shp_pkg::tap_type                rd_tap_ff, rd_tap_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic [shp_pkg::COORD_W-1:0]     row_ff, row_in;
   logic [shp_pkg::COORD_W-1:0]     col_ff, col_in;
   logic [shp_pkg::SIZE_W-1:0]      width_ff, width_in;
   logic [shp_pkg::SIZE_W-1:0]      height_ff, height_in;

   logic [shp_pkg::SIZE_W-1:0]      width_eff;
   logic [shp_pkg::SIZE_W-1:0]      height_eff;
   logic                            accept;
   logic                            in_range;
   logic                            ram_we;
   logic [ADDR_W-1:0]               ram_addr;
   logic [shp_pkg::PIX_W-1:0]       ram_rdata;
   shp_pkg::addr_req_type           areq;
   shp_pkg::mac_ctl_type            mac_ctl;
   logic [shp_pkg::PIX_W-1:0]       mac_value;

   // ---- size registers -----------------------------------------------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            shp_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            shp_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Clamp sizes to the legal span of the store.
   always_comb begin
      if (width_ff < shp_pkg::SIZE_MIN) begin
         width_eff = shp_pkg::SIZE_MIN;
      end else if (int'(width_ff) > MAX_COLS) begin
         width_eff = shp_pkg::SIZE_W'(MAX_COLS);
      end else begin
         width_eff = width_ff;
      end
      if (height_ff < shp_pkg::SIZE_MIN) begin
         height_eff = shp_pkg::SIZE_MIN;
      end else if (int'(height_ff) > MAX_ROWS) begin
         height_eff = shp_pkg::SIZE_W'(MAX_ROWS);
      end else begin
         height_eff = height_ff;
      end
   end

   // ---- request decode -----------------------------------------------------
   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign in_range = ({1'b0, req_item.pixel_row} < height_eff) &&
                     ({1'b0, req_item.pixel_col} < width_eff);
   assign ram_we   = accept && in_range && (req_item.opcode == shp_pkg::OP_WRITE);

   // ---- sequencer ----------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      tap_in      = tap_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      rd_valid_in = 1'b0;
      rd_tap_in   = tap_ff;
      case (state_ff)
         S_IDLE: begin
            // Latch the position and start the tap walk on an in-range read.
            if (accept && in_range && (req_item.opcode == shp_pkg::OP_READ)) begin
               state_in = S_FETCH;
               tap_in   = shp_pkg::TAP_CENTER;
               row_in   = req_item.pixel_row;
               col_in   = req_item.pixel_col;
            end
         end
         S_FETCH: begin
            // Issue one store read per cycle, advance the tap.
            rd_valid_in = 1'b1;
            case (tap_ff)
               shp_pkg::TAP_CENTER: tap_in = shp_pkg::TAP_UP;
               shp_pkg::TAP_UP:     tap_in = shp_pkg::TAP_DOWN;
               shp_pkg::TAP_DOWN:   tap_in = shp_pkg::TAP_LEFT;
               shp_pkg::TAP_LEFT:   tap_in = shp_pkg::TAP_RIGHT;
               default: begin
                  tap_in   = shp_pkg::TAP_CENTER;
                  state_in = S_LAST;
               end
            endcase
         end
         S_LAST: begin
            // Let the last neighbor land in the accumulator.
            state_in = S_OUT;
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         tap_ff      <= shp_pkg::TAP_CENTER;
         rd_valid_ff <= 1'b0;
         width_ff    <= shp_pkg::SIZE_RESET;
         height_ff   <= shp_pkg::SIZE_RESET;
      end else begin
         state_ff    <= state_in;
         tap_ff      <= tap_in;
         rd_valid_ff <= rd_valid_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      rd_tap_ff <= rd_tap_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
   end

   // ---- address path -------------------------------------------------------
   // While idle the port serves the incoming write at its center address.
   always_comb begin
      if (state_ff == S_IDLE) begin
         areq.row = req_item.pixel_row;
         areq.col = req_item.pixel_col;
         areq.tap = shp_pkg::TAP_CENTER;
      end else begin
         areq.row = row_ff;
         areq.col = col_ff;
         areq.tap = tap_ff;
      end
   end

   shp_addr_gen #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_addr_gen (
      .areq   (areq),
      .height (height_eff),
      .width  (width_eff),
      .addr   (ram_addr)
   );

   shp_ram #(
      .DATA_W (shp_pkg::PIX_W),
      .DEPTH  (DEPTH)
   ) u_pixel_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_item.pixel_value),
      .rdata (ram_rdata)
   );

   // ---- shared accumulator -------------------------------------------------
   assign mac_ctl.clear  = accept;
   assign mac_ctl.enable = rd_valid_ff;
   assign mac_ctl.tap    = rd_tap_ff;

   shp_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .data  (ram_rdata),
      .value (mac_value)
   );

   // ---- result -------------------------------------------------------------
   assign rsp_valid                = (state_ff == S_OUT);
   assign rsp_item.sharpened_value = mac_value;
   assign rsp_item.result_row      = row_ff;
   assign rsp_item.result_col      = col_ff;

   // ---- checks -------------------------------------------------------------
   `ASSERT_PROP(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "result strobe held over two cycles")
   `ASSERT_PROP(a_out_after_last, clock, reset, (state_ff == S_OUT) |-> $past(state_ff == S_LAST), "result without the last tap")
   `ASSERT_PROP(a_rd_in_walk, clock, reset, rd_valid_ff |-> ((state_ff == S_FETCH) || (state_ff == S_LAST)), "read data outside the tap walk")
   `ASSERT_NEVER(a_we_busy, clock, reset, ram_we && busy, "store write while a read is in flight")
   `ASSERT_PROP(a_read_busy, clock, reset, (accept && in_range && (req_item.opcode == shp_pkg::OP_READ)) |=> busy, "accepted read did not raise busy")

endmodule

`default_nettype wire
